/* sv/vqrc_pkg.sv */
// Shared types, constants and the quality table for the video quality rate controller.
// No dependencies.
package vqrc_pkg;

   localparam int FRAME_SIZE_BITS_DEF = 26;
   localparam int SIZE_WINDOW_DEF     = 3;

   localparam int NUM_LEVELS     = 7;
   localparam int LEVEL_BITS     = 3;
   localparam int RATE_BITS      = 5;
   localparam int FPS_BITS       = 10;
   localparam int SRC_BITS       = 8;
   localparam int QUAL_BITS      = 7;
   localparam int BYTE_RATE_BITS = 32;
   localparam int CNT_BITS       = 2;

   localparam logic [LEVEL_BITS-1:0] MID_LEVEL   = 3'd3;
   localparam logic [LEVEL_BITS-1:0] TOP_LEVEL   = 3'd6;
   localparam logic [LEVEL_BITS-1:0] FIXED_LEVEL = 3'd5;
   localparam logic [RATE_BITS-1:0]  MAX_RATE    = 5'd25;
   localparam logic [RATE_BITS-1:0]  MIN_RATE    = 5'd1;
   localparam logic [RATE_BITS-1:0]  RESET_RATE  = 5'd5;
   localparam logic [FPS_BITS-1:0]   STRICT_TH   = 10'd10;
   localparam logic [FPS_BITS-1:0]   PERMISSIVE_TH = 10'd5;
   localparam logic [FPS_BITS-1:0]   RATE_SAT    = 10'd1023;

   localparam logic [0:0] CSR_ENABLE    = 1'b0;
   localparam logic [0:0] CSR_BYTE_RATE = 1'b1;

   localparam logic [1:0] DIV_SEL_AVG       = 2'd0;
   localparam logic [1:0] DIV_SEL_SIZE      = 2'd1;
   localparam logic [1:0] DIV_SEL_MEAN_RATE = 2'd2;
   localparam logic [1:0] DIV_SEL_FINAL     = 2'd3;

   typedef struct packed {
      logic       load;
      logic       win_step;
      logic       search_wr;
      logic       trig_apply;
      logic       eval_step;
      logic       fin_read;
      logic       settle;
      logic       out_load;
      logic       div_start;
      logic [1:0] div_sel;
   } vqrc_cmd_type;

   typedef struct packed {
      logic enabled;
      logic size_zero;
      logic in_search;
      logic win_full;
      logic div_done;
      logic trigger;
      logic eval_done;
      logic out_free;
   } vqrc_status_type;

   function automatic logic [QUAL_BITS-1:0] quality_of(input logic [LEVEL_BITS-1:0] lv);
      logic [QUAL_BITS-1:0] q;
      case (lv)
         3'd0: q = 7'd20;
         3'd1: q = 7'd30;
         3'd2: q = 7'd40;
         3'd3: q = 7'd50;
         3'd4: q = 7'd60;
         3'd5: q = 7'd70;
         3'd6: q = 7'd80;
         default: q = 7'd0;
      endcase
      return q;
   endfunction

endpackage

/* sv/vqrc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module vqrc_ram #(
   parameter int WIDTH = 26,
   parameter int DEPTH = 7
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

/* sv/vqrc_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
module vqrc_div #(
   parameter int WIDTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [WIDTH-1:0] dividend,
   input  logic [WIDTH-1:0] divisor,
   output logic             done,
   output logic [WIDTH-1:0] quotient
);
   localparam int CW = $clog2(WIDTH + 1);

   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] den_ff, den_in;
   logic [WIDTH:0]   shifted;
   logic [WIDTH:0]   diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[WIDTH-1]};
      diff    = shifted - {1'b0, den_ff};
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      if (start) begin
         cnt_in  = CW'(WIDTH);
         busy_in = 1'b1;
         rem_in  = '0;
         quo_in  = dividend;
         den_in  = divisor;
      end else if (busy_ff) begin
         if (!diff[WIDTH]) begin
            rem_in = diff[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = shifted[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CW'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;
endmodule

/* sv/vqrc_datapath.sv */
// Datapath: configuration, search state, size window, divider, level size store, result register.
// Depends on vqrc_pkg, vqrc_div and vqrc_ram.
module vqrc_datapath #(
   parameter int FRAME_SIZE_BITS = 26,
   parameter int SIZE_WINDOW     = 3
) (
   input  logic                          clock,
   input  logic                          reset,
   input  vqrc_pkg::vqrc_cmd_type        cmd,
   output vqrc_pkg::vqrc_status_type     status,
   input  logic [FRAME_SIZE_BITS-1:0]    req_frame_size,
   input  logic [7:0]                    req_source_fps,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [2:0]                    rsp_quality_index,
   output logic [6:0]                    rsp_jpeg_quality,
   output logic [4:0]                    rsp_frame_rate,
   output logic                          rsp_evaluating,
   input  logic                          csr_write_enable,
   input  logic [0:0]                    csr_index,
   input  logic [31:0]                   csr_write_data
);
   import vqrc_pkg::*;

   localparam int FSB      = FRAME_SIZE_BITS;
   localparam int SUM_BITS = FSB + 2;
   localparam int DIV_BITS = (SUM_BITS > BYTE_RATE_BITS) ? SUM_BITS : BYTE_RATE_BITS;

   logic                      en_ff, en_in;
   logic [BYTE_RATE_BITS-1:0] byte_rate_ff, byte_rate_in;
   logic [FSB-1:0]            size_ff, size_in;
   logic [SRC_BITS-1:0]       src_ff, src_in;
   logic                      in_search_ff, in_search_in;
   logic [LEVEL_BITS-1:0]     level_ff, level_in;
   logic [RATE_BITS-1:0]      rate_ff, rate_in;
   logic [SUM_BITS-1:0]       sum_ff, sum_in;
   logic [CNT_BITS-1:0]       cnt_ff, cnt_in;
   logic [NUM_LEVELS-1:0]     valid_ff, valid_in;
   logic [LEVEL_BITS-1:0]     floor_level_ff, floor_level_in;
   logic [RATE_BITS-1:0]      floor_rate_ff, floor_rate_in;
   logic [LEVEL_BITS-1:0]     ceil_level_ff, ceil_level_in;
   logic [RATE_BITS-1:0]      ceil_rate_ff, ceil_rate_in;
   logic [FPS_BITS-1:0]       best_rate_ff, best_rate_in;
   logic [LEVEL_BITS-1:0]     best_level_ff, best_level_in;
   logic [LEVEL_BITS-1:0]     fin_ff, fin_in;
   logic [FSB-1:0]            avg_ff, avg_in;
   logic [FSB-1:0]            fsz_ff, fsz_in;
   logic                      den_zero_ff, den_zero_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_BITS-1:0]     rsp_level_ff, rsp_level_in;
   logic [QUAL_BITS-1:0]      rsp_qual_ff, rsp_qual_in;
   logic [RATE_BITS-1:0]      rsp_rate_ff, rsp_rate_in;
   logic                      rsp_eval_ff, rsp_eval_in;

   logic                      div_done;
   logic [DIV_BITS-1:0]       div_q;
   logic [DIV_BITS-1:0]       div_num, div_den;
   logic [FPS_BITS-1:0]       ach;
   logic [FSB-1:0]            ram_rdata;
   logic [FSB-1:0]            fin_size;
   logic                      ram_we;
   logic [FSB-1:0]            ram_wdata;
   logic [NUM_LEVELS:0]       valid_x;

   logic [CNT_BITS-1:0]       base_cnt;
   logic [SUM_BITS-1:0]       base_sum;
   logic [FPS_BITS-1:0]       rate_x, src_x;
   logic                      up_trig, down_trig;

   logic                      better;
   logic [FPS_BITS-1:0]       nb_rate;
   logic [LEVEL_BITS-1:0]     nb_level;
   logic [LEVEL_BITS-1:0]     lv_up, lv_dn, nl, fin;
   logic                      ev_done;
   logic [16:0]               fps_x100, floor_x66;
   logic                      strict_low;

   logic [FPS_BITS-1:0]       f1, f2;

   vqrc_div #(.WIDTH(DIV_BITS)) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (div_num),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_q)
   );

   vqrc_ram #(.WIDTH(FSB), .DEPTH(NUM_LEVELS)) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (level_ff),
      .wr_data (ram_wdata),
      .rd_en   (cmd.fin_read),
      .rd_addr (fin_ff),
      .rd_data (ram_rdata)
   );

   assign valid_x  = {1'b0, valid_ff};
   assign fin_size = valid_x[fin_ff] ? ram_rdata : '0;
   assign ram_we   = cmd.search_wr || cmd.trig_apply;
   assign ram_wdata = cmd.search_wr ? size_ff : avg_ff;

   always_comb begin
      case (cmd.div_sel)
         DIV_SEL_AVG: begin
            div_num = DIV_BITS'(sum_ff);
            div_den = DIV_BITS'(cnt_ff);
         end
         DIV_SEL_SIZE: begin
            div_num = DIV_BITS'(byte_rate_ff);
            div_den = DIV_BITS'(size_ff);
         end
         DIV_SEL_MEAN_RATE: begin
            div_num = DIV_BITS'(byte_rate_ff);
            div_den = DIV_BITS'(div_q[FSB-1:0]);
         end
         default: begin
            div_num = DIV_BITS'(byte_rate_ff);
            div_den = DIV_BITS'(fin_size);
         end
      endcase
   end

   always_comb begin
      if (byte_rate_ff == '0) begin
         ach = '0;
      end else if (den_zero_ff) begin
         ach = FPS_BITS'(MAX_RATE);
      end else if (div_q > DIV_BITS'(RATE_SAT)) begin
         ach = RATE_SAT;
      end else begin
         ach = div_q[FPS_BITS-1:0];
      end
   end

   // window and trigger
   always_comb begin
      base_cnt  = (cnt_ff >= CNT_BITS'(SIZE_WINDOW)) ? '0 : cnt_ff;
      base_sum  = (cnt_ff >= CNT_BITS'(SIZE_WINDOW)) ? '0 : sum_ff;
      rate_x    = FPS_BITS'(rate_ff);
      src_x     = FPS_BITS'(src_ff);
      up_trig   = (ach > rate_x) && ((rate_x < src_x) || (level_ff < TOP_LEVEL));
      down_trig = (ach < rate_x) && (ach < src_x);
   end

   // search evaluation
   always_comb begin
      better   = (ach > best_rate_ff) ||
                 (((ach == best_rate_ff) || (ach >= src_x)) && (level_ff > best_level_ff));
      nb_rate  = better ? ach : best_rate_ff;
      nb_level = better ? level_ff : best_level_ff;
      lv_up    = level_ff + 1'b1;
      lv_dn    = level_ff - 1'b1;
      fps_x100 = 17'(ach) * 17'd100;
      floor_x66 = 17'(floor_rate_ff) * 17'd66;
      strict_low = (ach < STRICT_TH) && (ach < src_x);
      nl       = level_ff;
      ev_done  = 1'b0;
      if ((level_ff > MID_LEVEL) && strict_low) begin
         nl      = lv_dn;
         ev_done = valid_x[lv_dn];
      end else if (((ach > PERMISSIVE_TH) && (fps_x100 >= floor_x66)) || (ach >= src_x)) begin
         if ((level_ff == TOP_LEVEL) || (level_ff >= ceil_level_ff) || valid_x[lv_up]) begin
            ev_done = 1'b1;
         end else if ((level_ff == MID_LEVEL) && strict_low) begin
            ev_done = 1'b1;
         end else begin
            nl = lv_up;
         end
      end else begin
         if ((level_ff == '0) || (level_ff <= floor_level_ff)) begin
            ev_done = 1'b1;
         end else begin
            nl      = lv_dn;
            ev_done = valid_x[lv_dn];
         end
      end
      fin = ((nb_rate != '0) && (nb_level > nl)) ? nb_level : nl;
   end

   // settled rate
   always_comb begin
      f1 = ((fin_ff == floor_level_ff) && (ach < FPS_BITS'(floor_rate_ff))) ?
           FPS_BITS'(floor_rate_ff) : ach;
      f2 = ((fin_ff == ceil_level_ff) && (f1 > FPS_BITS'(ceil_rate_ff))) ?
           FPS_BITS'(ceil_rate_ff) : f1;
      if (f2 < FPS_BITS'(MIN_RATE)) begin
         f2 = FPS_BITS'(MIN_RATE);
      end else if (f2 > FPS_BITS'(MAX_RATE)) begin
         f2 = FPS_BITS'(MAX_RATE);
      end
   end

   always_comb begin
      en_in          = en_ff;
      byte_rate_in   = byte_rate_ff;
      size_in        = size_ff;
      src_in         = src_ff;
      in_search_in   = in_search_ff;
      level_in       = level_ff;
      rate_in        = rate_ff;
      sum_in         = sum_ff;
      cnt_in         = cnt_ff;
      valid_in       = valid_ff;
      floor_level_in = floor_level_ff;
      floor_rate_in  = floor_rate_ff;
      ceil_level_in  = ceil_level_ff;
      ceil_rate_in   = ceil_rate_ff;
      best_rate_in   = best_rate_ff;
      best_level_in  = best_level_ff;
      fin_in         = fin_ff;
      avg_in         = avg_ff;
      fsz_in         = fsz_ff;
      den_zero_in    = den_zero_ff;
      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_level_in   = rsp_level_ff;
      rsp_qual_in    = rsp_qual_ff;
      rsp_rate_in    = rsp_rate_ff;
      rsp_eval_in    = rsp_eval_ff;

      if (csr_write_enable) begin
         case (csr_index)
            CSR_ENABLE:    en_in        = csr_write_data[0];
            CSR_BYTE_RATE: byte_rate_in = csr_write_data;
            default: ;
         endcase
      end
      if (cmd.load) begin
         size_in = req_frame_size;
         src_in  = req_source_fps;
      end
      if (cmd.div_start) begin
         den_zero_in = (div_den == '0);
         if (cmd.div_sel == DIV_SEL_MEAN_RATE) begin
            avg_in = div_q[FSB-1:0];
         end
         if (cmd.div_sel == DIV_SEL_FINAL) begin
            fsz_in = fin_size;
         end
      end
      if (cmd.win_step) begin
         sum_in = base_sum + SUM_BITS'(size_ff);
         cnt_in = base_cnt + 1'b1;
      end
      if (cmd.search_wr) begin
         valid_in[level_ff] = 1'b1;
      end
      if (cmd.trig_apply) begin
         in_search_in       = 1'b1;
         valid_in[level_ff] = 1'b1;
         if (up_trig) begin
            floor_level_in = level_ff;
            floor_rate_in  = rate_ff;
         end else begin
            ceil_level_in = level_ff;
            ceil_rate_in  = rate_ff;
         end
      end
      if (cmd.eval_step) begin
         level_in      = nl;
         best_rate_in  = nb_rate;
         best_level_in = nb_level;
         fin_in        = fin;
      end
      if (cmd.settle) begin
         in_search_in   = 1'b0;
         level_in       = fin_ff;
         valid_in       = '0;
         floor_level_in = '0;
         floor_rate_in  = '0;
         ceil_level_in  = TOP_LEVEL;
         ceil_rate_in   = MAX_RATE;
         best_rate_in   = '0;
         best_level_in  = '0;
         rate_in        = f2[RATE_BITS-1:0];
         sum_in         = SUM_BITS'(fsz_ff);
         cnt_in         = CNT_BITS'(1);
      end
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
         if (en_ff) begin
            rsp_level_in = level_ff;
            rsp_qual_in  = quality_of(level_ff);
            rsp_rate_in  = rate_ff;
            rsp_eval_in  = in_search_ff;
         end else begin
            rsp_level_in = FIXED_LEVEL;
            rsp_qual_in  = quality_of(FIXED_LEVEL);
            rsp_rate_in  = MAX_RATE;
            rsp_eval_in  = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         en_ff          <= 1'b1;
         byte_rate_ff   <= '0;
         in_search_ff   <= 1'b1;
         level_ff       <= MID_LEVEL;
         rate_ff        <= RESET_RATE;
         sum_ff         <= '0;
         cnt_ff         <= '0;
         valid_ff       <= '0;
         floor_level_ff <= '0;
         floor_rate_ff  <= '0;
         ceil_level_ff  <= TOP_LEVEL;
         ceil_rate_ff   <= MAX_RATE;
         best_rate_ff   <= '0;
         best_level_ff  <= '0;
         fin_ff         <= '0;
         den_zero_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         en_ff          <= en_in;
         byte_rate_ff   <= byte_rate_in;
         in_search_ff   <= in_search_in;
         level_ff       <= level_in;
         rate_ff        <= rate_in;
         sum_ff         <= sum_in;
         cnt_ff         <= cnt_in;
         valid_ff       <= valid_in;
         floor_level_ff <= floor_level_in;
         floor_rate_ff  <= floor_rate_in;
         ceil_level_ff  <= ceil_level_in;
         ceil_rate_ff   <= ceil_rate_in;
         best_rate_ff   <= best_rate_in;
         best_level_ff  <= best_level_in;
         fin_ff         <= fin_in;
         den_zero_ff    <= den_zero_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      size_ff      <= size_in;
      src_ff       <= src_in;
      avg_ff       <= avg_in;
      fsz_ff       <= fsz_in;
      rsp_level_ff <= rsp_level_in;
      rsp_qual_ff  <= rsp_qual_in;
      rsp_rate_ff  <= rsp_rate_in;
      rsp_eval_ff  <= rsp_eval_in;
   end

   always_comb begin
      status.enabled   = en_ff;
      status.size_zero = (size_ff == '0);
      status.in_search = in_search_ff;
      status.win_full  = (cnt_ff >= CNT_BITS'(SIZE_WINDOW)) ||
                         (RATE_BITS'(cnt_ff) >= rate_ff);
      status.div_done  = div_done;
      status.trigger   = up_trig || down_trig;
      status.eval_done = ev_done;
      status.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_quality_index = rsp_level_ff;
   assign rsp_jpeg_quality  = rsp_qual_ff;
   assign rsp_frame_rate    = rsp_rate_ff;
   assign rsp_evaluating    = rsp_eval_ff;
endmodule

/* sv/vqrc_ctrl.sv */
// Controller state machine: sequences window, search, divisions and result hand-off.
// Depends on vqrc_pkg.
module vqrc_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  vqrc_pkg::vqrc_status_type status,
   output vqrc_pkg::vqrc_cmd_type    cmd
);
   import vqrc_pkg::*;

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_DISP   = 4'd1;
   localparam logic [3:0] S_WIN    = 4'd2;
   localparam logic [3:0] S_WCHK   = 4'd3;
   localparam logic [3:0] S_AVGS   = 4'd4;
   localparam logic [3:0] S_AVGW   = 4'd5;
   localparam logic [3:0] S_NFW    = 4'd6;
   localparam logic [3:0] S_DEC    = 4'd7;
   localparam logic [3:0] S_SWR    = 4'd8;
   localparam logic [3:0] S_SW     = 4'd9;
   localparam logic [3:0] S_EVAL   = 4'd10;
   localparam logic [3:0] S_RD     = 4'd11;
   localparam logic [3:0] S_FDIV   = 4'd12;
   localparam logic [3:0] S_FW     = 4'd13;
   localparam logic [3:0] S_SETTLE = 4'd14;
   localparam logic [3:0] S_OUT    = 4'd15;

   logic [3:0] state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            if (!status.enabled || status.size_zero) begin
               state_in = S_OUT;
            end else if (status.in_search) begin
               state_in = S_SWR;
            end else begin
               state_in = S_WIN;
            end
         end
         S_WIN: begin
            cmd.win_step = 1'b1;
            state_in     = S_WCHK;
         end
         S_WCHK: begin
            state_in = status.win_full ? S_AVGS : S_OUT;
         end
         S_AVGS: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_SEL_AVG;
            state_in      = S_AVGW;
         end
         S_AVGW: begin
            if (status.div_done) begin
               cmd.div_start = 1'b1;
               cmd.div_sel   = DIV_SEL_MEAN_RATE;
               state_in      = S_NFW;
            end
         end
         S_NFW: begin
            if (status.div_done) begin
               state_in = S_DEC;
            end
         end
         S_DEC: begin
            if (status.trigger) begin
               cmd.trig_apply = 1'b1;
               state_in       = S_EVAL;
            end else begin
               state_in = S_OUT;
            end
         end
         S_SWR: begin
            cmd.search_wr = 1'b1;
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_SEL_SIZE;
            state_in      = S_SW;
         end
         S_SW: begin
            if (status.div_done) begin
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.eval_step = 1'b1;
            state_in      = status.eval_done ? S_RD : S_OUT;
         end
         S_RD: begin
            cmd.fin_read = 1'b1;
            state_in     = S_FDIV;
         end
         S_FDIV: begin
            cmd.div_start = 1'b1;
            cmd.div_sel   = DIV_SEL_FINAL;
            state_in      = S_FW;
         end
         S_FW: begin
            if (status.div_done) begin
               state_in = S_SETTLE;
            end
         end
         S_SETTLE: begin
            cmd.settle = 1'b1;
            state_in   = S_OUT;
         end
         S_OUT: begin
            if (status.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
endmodule

/* sv/video_quality_rate_controller.sv */
// Top level of the video quality rate controller: controller and datapath.
// Depends on vqrc_pkg, vqrc_ctrl and vqrc_datapath.
//
// One item per finished frame gives its encoded size and the source frame rate; one result
// gives the quality level, its JPEG quality, the stream frame rate and the search flag. Items
// are handled one at a time. Each division runs on one shared restoring divider at one
// quotient bit per cycle: a search frame needs one or two divisions, a full window up to
// three. A new item may be taken while the previous result still waits.
module video_quality_rate_controller #(
   parameter int FRAME_SIZE_BITS = vqrc_pkg::FRAME_SIZE_BITS_DEF,
   parameter int SIZE_WINDOW     = vqrc_pkg::SIZE_WINDOW_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [FRAME_SIZE_BITS-1:0] req_frame_size,
   input  logic [7:0]                 req_source_fps,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic [2:0]                 rsp_quality_index,
   output logic [6:0]                 rsp_jpeg_quality,
   output logic [4:0]                 rsp_frame_rate,
   output logic                       rsp_evaluating,
   input  logic                       csr_write_enable,
   input  logic [0:0]                 csr_index,
   input  logic [31:0]                csr_write_data
);
   import vqrc_pkg::*;

   vqrc_cmd_type    cmd;
   vqrc_status_type status;

   vqrc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   vqrc_datapath #(
      .FRAME_SIZE_BITS (FRAME_SIZE_BITS),
      .SIZE_WINDOW     (SIZE_WINDOW)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_frame_size    (req_frame_size),
      .req_source_fps    (req_source_fps),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_quality_index (rsp_quality_index),
      .rsp_jpeg_quality  (rsp_jpeg_quality),
      .rsp_frame_rate    (rsp_frame_rate),
      .rsp_evaluating    (rsp_evaluating),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data)
   );
endmodule
